>>> rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types, microcode and chirp tables for the chirp tone sequencer.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int MAX_SEGMENT_SAMPLES_DEF = 4096;

  localparam int SAMPLE_W = 14;
  localparam int AMP_W    = 13;
  localparam int LEN_W    = 12;
  localparam int HP_W     = 6;
  localparam int FADE_W   = 8;
  localparam int EFFECT_W = 3;
  localparam int SEGIDX_W = 2;
  localparam int DIV_W    = AMP_W + FADE_W;
  localparam int CNT_W    = $clog2(DIV_W);
  localparam int PC_W     = 3;

  localparam logic OPER_START = 1'b0;
  localparam logic OPER_TICK  = 1'b1;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t STEP_FETCH  = 3'd0;
  localparam pc_t STEP_DECODE = 3'd1;
  localparam pc_t STEP_CHECK  = 3'd2;
  localparam pc_t STEP_MUL    = 3'd3;
  localparam pc_t STEP_DIV    = 3'd4;
  localparam pc_t STEP_ADV    = 3'd5;
  localparam pc_t STEP_LOOP   = 3'd6;
  localparam pc_t STEP_START  = 3'd7;

  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_FETCH,
    UOP_START,
    UOP_MUL,
    UOP_DIV,
    UOP_ADV
  } uop_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_IS_START,
    COND_IDLE,
    COND_NO_FADE,
    COND_DIV_BUSY,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    pc_t   target;
    logic  ready;
  } ctrl_word_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [HP_W-1:0]   half_period;
    logic [AMP_W-1:0]  amp;
    logic              tone;
    logic [FADE_W-1:0] fade;
  } seg_desc_t;

  // Each step jumps to its target when its condition holds, else falls through.
  function automatic ctrl_word_t ucode(input pc_t pc);
    ctrl_word_t w;
    w = '{uop: UOP_NOP, cond: COND_ALWAYS, target: STEP_FETCH, ready: 1'b0};
    unique case (pc)
      STEP_FETCH:  w = '{uop: UOP_FETCH, cond: COND_NO_INPUT, target: STEP_FETCH, ready: 1'b1};
      STEP_DECODE: w = '{uop: UOP_NOP, cond: COND_IS_START, target: STEP_START, ready: 1'b0};
      STEP_CHECK:  w = '{uop: UOP_NOP, cond: COND_IDLE, target: STEP_ADV, ready: 1'b0};
      STEP_MUL:    w = '{uop: UOP_MUL, cond: COND_NO_FADE, target: STEP_ADV, ready: 1'b0};
      STEP_DIV:    w = '{uop: UOP_DIV, cond: COND_DIV_BUSY, target: STEP_DIV, ready: 1'b0};
      STEP_ADV:    w = '{uop: UOP_ADV, cond: COND_OUT_BUSY, target: STEP_ADV, ready: 1'b0};
      STEP_LOOP:   w = '{uop: UOP_NOP, cond: COND_ALWAYS, target: STEP_FETCH, ready: 1'b0};
      STEP_START:  w = '{uop: UOP_START, cond: COND_ALWAYS, target: STEP_FETCH, ready: 1'b0};
      default:     w = '{uop: UOP_NOP, cond: COND_ALWAYS, target: STEP_FETCH, ready: 1'b0};
    endcase
    return w;
  endfunction

  // Half periods are 16000 / (2 * hz), truncated. Fades are len / 16, at least 16.
  function automatic seg_desc_t seg_lookup(input logic [EFFECT_W-1:0] eff,
                                           input logic [SEGIDX_W-1:0] idx);
    seg_desc_t s;
    s = '{len: 12'd0, half_period: 6'd1, amp: 13'd0, tone: 1'b0, fade: 8'd16};
    unique case (eff)
      3'd0: if (idx == 2'd0) s = '{12'd1280, 6'd9, 13'd4000, 1'b1, 8'd80};
      3'd1: if (idx == 2'd0) s = '{12'd1280, 6'd12, 13'd4000, 1'b1, 8'd80};
      3'd2: begin
        if (idx == 2'd0 || idx == 2'd2) s = '{12'd640, 6'd6, 13'd5000, 1'b1, 8'd40};
        else if (idx == 2'd1) s = '{12'd80, 6'd1, 13'd0, 1'b0, 8'd16};
      end
      3'd3: begin
        if (idx == 2'd0) s = '{12'd1440, 6'd8, 13'd4500, 1'b1, 8'd90};
        else if (idx == 2'd1) s = '{12'd1440, 6'd6, 13'd4500, 1'b1, 8'd90};
      end
      3'd4: begin
        if (idx == 2'd0) s = '{12'd1120, 6'd15, 13'd4000, 1'b1, 8'd70};
        else if (idx == 2'd1) s = '{12'd1120, 6'd10, 13'd4000, 1'b1, 8'd70};
      end
      default: if (idx == 2'd0) s = '{12'd2880, 6'd40, 13'd3500, 1'b1, 8'd180};
    endcase
    return s;
  endfunction

  function automatic logic [SEGIDX_W-1:0] chirp_count(input logic [EFFECT_W-1:0] eff);
    logic [SEGIDX_W-1:0] c;
    unique case (eff)
      3'd2:        c = 2'd3;
      3'd3, 3'd4:  c = 2'd2;
      default:     c = 2'd1;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/chirp_tone_sequencer_top.sv
// ----------------------------------------------------------------------------
// chirp_tone_sequencer_top
// Microcoded square-wave chirp player with linear fades, one sample per tick.
// ----------------------------------------------------------------------------
// The input channel carries start and tick transfers. A start transfer picks a
// chirp by in_effect and restarts playback unless cfg_wr_data was last written
// as 1 (muted); it produces no result. Each tick transfer produces exactly one
// result transfer on the output channel: a signed sample, an active flag and a
// last flag on the final sample of the chirp. Ticks while idle give zeros.
// A small program in a constant table sequences the datapath, one step per
// cycle. A start and an idle tick skip the multiply and the divide, a tick
// outside the fade ramps skips the divide, and a tick inside a ramp runs the
// restoring divider, which retires one quotient bit per cycle over 21 bits.
// The result sits in an output register; the next input transfer is taken
// while it waits. If the receiver stalls, the sequencer holds in its
// result step until the register is free.
// A synchronous reset clears playback, the mute bit and the output valid.
// ----------------------------------------------------------------------------
module chirp_tone_sequencer_top #(
  parameter int MAX_SEGMENT_SAMPLES = cts_pkg::MAX_SEGMENT_SAMPLES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic                                   cfg_wr_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_operation,
  input  logic [cts_pkg::EFFECT_W-1:0]           in_effect,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [cts_pkg::SAMPLE_W-1:0]    out_sample,
  output logic                                   out_active,
  output logic                                   out_last
);
  import cts_pkg::*;

  localparam int POS_W = $clog2(MAX_SEGMENT_SAMPLES);
  localparam int N_W   = POS_W + 1;

  ctrl_word_t cw;

  pc_t                        pc_r, pc_nxt;
  logic                       muted_r, muted_nxt;
  logic                       playing_r, playing_nxt;
  logic [EFFECT_W-1:0]        effect_r, effect_nxt;
  logic [SEGIDX_W-1:0]        seg_idx_r, seg_idx_nxt;
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic [HP_W-1:0]            hp_r, hp_nxt;
  logic                       sign_r, sign_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic                       in_op_r, in_op_nxt;
  logic [EFFECT_W-1:0]        in_eff_r, in_eff_nxt;
  logic [DIV_W-1:0]           div_r, div_nxt;
  logic [FADE_W-1:0]          rem_r, rem_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                       out_active_r, out_active_nxt;
  logic                       out_last_r, out_last_nxt;

  logic [EFFECT_W-1:0]        lk_eff;
  logic [SEGIDX_W-1:0]        lk_idx;
  logic [SEGIDX_W-1:0]        idx_inc;
  seg_desc_t                  cur, nxt_seg;
  logic [N_W-1:0]             seg_n, pos_ext, pos_inc, tail_k;
  logic                       in_head, in_tail, no_fade, cond_hit;
  logic [FADE_W-1:0]          k;
  logic [DIV_W-1:0]           prod;
  logic [FADE_W:0]            rem_sh;
  logic                       q_bit;
  logic [SAMPLE_W-1:0]        mag;

  assign cw = ucode(pc_r);

  assign lk_eff  = (cw.uop == UOP_START) ? in_eff_r : effect_r;
  assign lk_idx  = (cw.uop == UOP_START) ? '0 : seg_idx_r;
  assign idx_inc = seg_idx_r + 1'b1;
  assign cur     = seg_lookup(lk_eff, lk_idx);
  assign nxt_seg = seg_lookup(effect_r, idx_inc);

  assign seg_n   = (32'(cur.len) > MAX_SEGMENT_SAMPLES) ? N_W'(MAX_SEGMENT_SAMPLES)
                                                        : N_W'(cur.len);
  assign pos_ext = {1'b0, pos_r};
  assign pos_inc = pos_ext + 1'b1;
  assign tail_k  = seg_n - 1'b1 - pos_ext;
  assign in_head = pos_ext < N_W'(cur.fade);
  assign in_tail = pos_ext >= (seg_n - N_W'(cur.fade));
  assign no_fade = !cur.tone || !(in_head || in_tail);
  assign k       = in_head ? pos_r[FADE_W-1:0] : tail_k[FADE_W-1:0];
  assign prod    = DIV_W'(cur.amp) * DIV_W'(k);

  assign rem_sh  = {rem_r, div_r[DIV_W-1]};
  assign q_bit   = rem_sh >= {1'b0, cur.fade};
  assign mag     = SAMPLE_W'(div_r[AMP_W-1:0]);

  always_comb begin
    unique case (cw.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_NO_INPUT: cond_hit = !in_valid;
      COND_IS_START: cond_hit = (in_op_r == OPER_START);
      COND_IDLE:     cond_hit = !playing_r;
      COND_NO_FADE:  cond_hit = no_fade;
      COND_DIV_BUSY: cond_hit = (cnt_r != '0);
      COND_OUT_BUSY: cond_hit = out_valid_r && !out_ready;
      default:       cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt         = cond_hit ? cw.target : pc_t'(pc_r + 1'b1);
    muted_nxt      = cfg_wr_en ? cfg_wr_data : muted_r;
    playing_nxt    = playing_r;
    effect_nxt     = effect_r;
    seg_idx_nxt    = seg_idx_r;
    pos_nxt        = pos_r;
    hp_nxt         = hp_r;
    sign_nxt       = sign_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    in_op_nxt      = in_op_r;
    in_eff_nxt     = in_eff_r;
    div_nxt        = div_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    out_sample_nxt = out_sample_r;
    out_active_nxt = out_active_r;
    out_last_nxt   = out_last_r;

    unique case (cw.uop)
      UOP_NOP: begin
      end
      UOP_FETCH: begin
        if (in_valid) begin
          in_op_nxt  = in_operation;
          in_eff_nxt = in_effect;
        end
      end
      UOP_START: begin
        if (!muted_r) begin
          playing_nxt = 1'b1;
          effect_nxt  = in_eff_r;
          seg_idx_nxt = '0;
          pos_nxt     = '0;
          sign_nxt    = 1'b0;
          hp_nxt      = cur.half_period;
        end
      end
      UOP_MUL: begin
        div_nxt = no_fade ? DIV_W'(cur.amp) : prod;
        rem_nxt = '0;
        cnt_nxt = CNT_W'(DIV_W - 1);
      end
      UOP_DIV: begin
        rem_nxt = q_bit ? FADE_W'(rem_sh - {1'b0, cur.fade}) : rem_sh[FADE_W-1:0];
        div_nxt = {div_r[DIV_W-2:0], q_bit};
        cnt_nxt = cnt_r - 1'b1;
      end
      UOP_ADV: begin
        if (!(out_valid_r && !out_ready)) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = '0;
          out_active_nxt = playing_r;
          out_last_nxt   = 1'b0;
          if (playing_r) begin
            if (cur.tone) begin
              out_sample_nxt = sign_r ? -mag : mag;
              if (hp_r <= HP_W'(1)) begin
                sign_nxt = !sign_r;
                hp_nxt   = cur.half_period;
              end else begin
                hp_nxt = hp_r - 1'b1;
              end
            end
            pos_nxt = pos_inc[POS_W-1:0];
            if (pos_inc >= seg_n) begin
              if (idx_inc >= chirp_count(effect_r)) begin
                playing_nxt  = 1'b0;
                seg_idx_nxt  = '0;
                pos_nxt      = '0;
                hp_nxt       = '0;
                sign_nxt     = 1'b0;
                out_last_nxt = 1'b1;
              end else begin
                seg_idx_nxt = idx_inc;
                pos_nxt     = '0;
                sign_nxt    = 1'b0;
                hp_nxt      = nxt_seg.half_period;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_FETCH;
      muted_r     <= 1'b0;
      playing_r   <= 1'b0;
      effect_r    <= '0;
      seg_idx_r   <= '0;
      pos_r       <= '0;
      hp_r        <= '0;
      sign_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      muted_r     <= muted_nxt;
      playing_r   <= playing_nxt;
      effect_r    <= effect_nxt;
      seg_idx_r   <= seg_idx_nxt;
      pos_r       <= pos_nxt;
      hp_r        <= hp_nxt;
      sign_r      <= sign_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_op_r      <= in_op_nxt;
    in_eff_r     <= in_eff_nxt;
    div_r        <= div_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    out_sample_r <= out_sample_nxt;
    out_active_r <= out_active_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ready   = cw.ready;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_active = out_active_r;
  assign out_last   = out_last_r;

endmodule

>>> rtl/cts_checker.sv
// ----------------------------------------------------------------------------
// cts_checker
// Port-level checks for the chirp tone sequencer, bound to its top level.
// ----------------------------------------------------------------------------
module cts_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [cts_pkg::SAMPLE_W-1:0] out_sample,
  input logic                                out_active,
  input logic                                out_last
);
  import cts_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_last))
    else $error("result dropped or changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_active |-> out_sample == '0 && !out_last)
    else $error("idle result carries a sample or a last flag");

  a_last_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_active)
    else $error("last flag on an inactive result");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample >= -14'sd5000 && out_sample <= 14'sd5000)
    else $error("sample outside the amplitude range");

endmodule

bind chirp_tone_sequencer_top cts_checker u_cts_checker (.*);

>>> tb/sv/chirp_tone_sequencer_top_test.sv
// ----------------------------------------------------------------------------
// chirp_tone_sequencer_top_test
// Self-checking bench for the chirp tone sequencer. Every accepted input
// transfer runs through a cycle-free model of the chirp player, and each
// sample transfer is compared with the oldest predicted sample. Stimulus is
// a short directed set, one long poke session through its tail ramp and its
// silent gap, then random sessions and noise under alternating mute settings,
// with bursty input pacing and a wandering output stall pattern.
// ----------------------------------------------------------------------------
module chirp_tone_sequencer_top_test;
  import cts_pkg::*;

  localparam int SEG_LIMIT     = MAX_SEGMENT_SAMPLES_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int ITEM_TARGET   = 1050;
  localparam int POKE_TICKS    = 730;

  localparam int FX_LISTEN  = 0;
  localparam int FX_RELEASE = 1;
  localparam int FX_POKE    = 2;
  localparam int FX_NOTICE  = 3;
  localparam int FX_OK      = 4;
  localparam int FX_NOPE    = 5;
  localparam int FX_LAST    = 7;

  typedef enum int {RX_OPEN, RX_COIN, RX_THIRD, RX_BURSTY} rx_mode_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                active;
    logic                last;
  } tone_sample_t;

  class chirp_scoreboard;
    bit muted;
    bit playing;
    int effect;
    int seg;
    int pos;
    int hp_left;
    bit neg;
    int errors;
    tone_sample_t pending_samples[$];

    function new();
      muted   = 1'b0;
      playing = 1'b0;
      effect  = 0;
      seg     = 0;
      pos     = 0;
      hp_left = 0;
      neg     = 1'b0;
      errors  = 0;
    endfunction

    function void shape(int eff, int idx, output int len, output int hz, output int amp);
      len = 0;
      hz  = 0;
      amp = 0;
      case (eff)
        FX_LISTEN: if (idx == 0) begin
          len = 1280; hz = 880; amp = 4000;
        end
        FX_RELEASE: if (idx == 0) begin
          len = 1280; hz = 660; amp = 4000;
        end
        FX_POKE: if (idx == 1) begin
          len = 80;
        end else if (idx == 0 || idx == 2) begin
          len = 640; hz = 1320; amp = 5000;
        end
        FX_NOTICE: if (idx == 0) begin
          len = 1440; hz = 988; amp = 4500;
        end else if (idx == 1) begin
          len = 1440; hz = 1318; amp = 4500;
        end
        FX_OK: if (idx == 0) begin
          len = 1120; hz = 523; amp = 4000;
        end else if (idx == 1) begin
          len = 1120; hz = 784; amp = 4000;
        end
        default: if (idx == 0) begin
          len = 2880; hz = 200; amp = 3500;
        end
      endcase
      if (len > SEG_LIMIT) len = SEG_LIMIT;
    endfunction

    function int segments(int eff);
      if (eff == FX_POKE) return 3;
      if (eff == FX_NOTICE || eff == FX_OK) return 2;
      return 1;
    endfunction

    function int half_period(int hz);
      int h;
      if (hz == 0) return 1;
      h = 16000 / (2 * hz);
      return (h < 1) ? 1 : h;
    endfunction

    function void start_segment();
      int len, hz, amp;
      shape(effect, seg % 3, len, hz, amp);
      pos     = 0;
      neg     = 1'b0;
      hp_left = half_period(hz);
    endfunction

    function int ramp(int v, int p, int n);
      int fade;
      fade = n / 16;
      if (fade < 16) fade = 16;
      if (fade * 2 > n) fade = n / 4;
      if (fade <= 0) return v;
      if (p < fade) return v * p / fade;
      if (p >= n - fade) return v * (n - 1 - p) / fade;
      return v;
    endfunction

    function void take_input(logic op, logic [EFFECT_W-1:0] eff);
      int len, hz, amp, v;
      bit last, was_playing;
      tone_sample_t r;
      if (op == OPER_START) begin
        if (!muted) begin
          effect  = int'(eff);
          seg     = 0;
          playing = 1'b1;
          start_segment();
        end
        return;
      end
      v = 0;
      last = 1'b0;
      was_playing = playing;
      if (playing) begin
        shape(effect, seg % 3, len, hz, amp);
        if (hz != 0) begin
          v = neg ? -amp : amp;
          v = ramp(v, pos, len);
          if (hp_left <= 1) begin
            neg = !neg;
            hp_left = half_period(hz);
          end else begin
            hp_left--;
          end
        end
        pos++;
        if (pos >= len) begin
          seg++;
          if (seg >= segments(effect)) begin
            playing = 1'b0;
            seg     = 0;
            pos     = 0;
            hp_left = 0;
            neg     = 1'b0;
            last    = 1'b1;
          end else begin
            start_segment();
          end
        end
      end
      r.sample = v[SAMPLE_W-1:0];
      r.active = was_playing;
      r.last   = last;
      pending_samples.push_back(r);
    endfunction

    function void check_sample(logic [SAMPLE_W-1:0] sample, logic active, logic last);
      tone_sample_t want;
      if (pending_samples.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected sample transfer: sample %0d active %0b last %0b",
                   $signed(sample), active, last);
        return;
      end
      want = pending_samples.pop_front();
      if (want.sample !== sample || want.active !== active || want.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("sample mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                   $signed(want.sample), want.active, want.last,
                   $signed(sample), active, last);
      end
    endfunction

    function void close();
      if (pending_samples.size() != 0) begin
        if (errors < 10)
          $display("%0d predicted samples never arrived", pending_samples.size());
        errors += pending_samples.size();
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic                       cfg_wr_data;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_operation;
  logic [EFFECT_W-1:0]        in_effect;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_active;
  logic                       out_last;

  chirp_tone_sequencer_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_effect    (in_effect),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample   (out_sample),
    .out_active   (out_active),
    .out_last     (out_last)
  );

  chirp_scoreboard sb;
  int burst_left;
  int items_sent;
  int cycles = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int rx_left = 0;
  int rx_stall = 0;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("chirp_tone_sequencer_top_test: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_sample(out_sample, out_active, out_last);
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(50, 300);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom_range(0, 1));
      RX_THIRD: out_ready <= (rx_left % 3 == 0);
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 15);
        end
      end
    endcase
  end

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = $urandom_range(1, 8);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 12);
  endtask

  task automatic send_item(input logic op, input logic [EFFECT_W-1:0] eff);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_effect    <= eff;
    do @(posedge clk); while (!in_ready);
    sb.take_input(op, eff);
    items_sent++;
    pace();
  endtask

  task automatic play(input int eff, input int ticks);
    send_item(OPER_START, EFFECT_W'(eff));
    repeat (ticks) send_item(OPER_TICK, EFFECT_W'($urandom_range(0, 7)));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mute(input logic m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.muted = m;
  endtask

  initial begin
    int phase, target, r, ticks, base;
    sb = new();
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= 1'b0;
    in_effect    <= '0;
    out_ready    <= 1'b0;
    burst_left = 0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OPER_TICK, EFFECT_W'(FX_LAST));
    play(FX_LAST, 2);
    play(FX_LISTEN, 3);
    play(FX_POKE, 2);
    settle();
    write_mute(1'b1);
    send_item(OPER_START, EFFECT_W'(FX_NOPE));
    send_item(OPER_TICK, EFFECT_W'(FX_LISTEN));
    send_item(OPER_TICK, EFFECT_W'(FX_LAST));
    send_item(OPER_START, EFFECT_W'(6));
    send_item(OPER_TICK, EFFECT_W'(FX_OK));
    settle();
    write_mute(1'b0);
    play(6, 1);
    play(FX_RELEASE, 1);
    play(FX_NOTICE, 1);
    play(FX_OK, 1);

    play(FX_POKE, POKE_TICKS);

    base = items_sent;
    for (phase = 0; phase < 4; phase++) begin
      play($urandom_range(0, 7), $urandom_range(20, 60));
      settle();
      write_mute((phase % 2) == 0);
      target = base + (ITEM_TARGET - base) * (phase + 1) / 4;
      while (items_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          ticks = ($urandom_range(0, 11) == 0) ? $urandom_range(300, 800) : $urandom_range(1, 120);
          if (ticks > target - items_sent) ticks = target - items_sent;
          play($urandom_range(0, 7), ticks);
        end else if (r < 96) begin
          send_item(1'($urandom_range(0, 1)), EFFECT_W'($urandom_range(0, 7)));
        end else begin
          settle();
        end
      end
    end

    settle();
    sb.close();
    if (sb.errors == 0) begin
      $display("chirp_tone_sequencer_top_test: clean");
    end else begin
      $display("chirp_tone_sequencer_top_test: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/cts_pkg.sv
rtl/chirp_tone_sequencer_top.sv
rtl/cts_checker.sv
tb/sv/chirp_tone_sequencer_top_test.sv
